// ===== src/http2_frame_parser_defines.svh =====
// Assertion macros used by the HTTP/2 frame parser RTL.
// Depends on nothing; taken in by h2fp_queue, the file that carries assertions.
`ifndef HTTP2_FRAME_PARSER_DEFINES_SVH
`define HTTP2_FRAME_PARSER_DEFINES_SVH

// Check that a property holds at every rising clock edge outside reset
`define H2FP_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset
`define H2FP_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/h2fp_pkg.sv =====
// Package of the HTTP/2 frame parser: event codes, frame type codes and the event record.
// Used by the event interface and by every module of the parser.
`timescale 1ns / 1ps
package h2fp_pkg;

    localparam int QueueDepth = 4;
    localparam logic [23:0] MaxFrameSizeReset = 24'd16384;

    typedef enum logic [2:0] {
        EV_BODY  = 3'd0,
        EV_END   = 3'd1,
        EV_PRIO  = 3'd2,
        EV_RST   = 3'd3,
        EV_SET   = 3'd4,
        EV_PING  = 3'd5,
        EV_ERR   = 3'd6
    } t_ev_code;

    localparam logic [7:0] TypeData  = 8'h0;
    localparam logic [7:0] TypePrio  = 8'h2;
    localparam logic [7:0] TypeRst   = 8'h3;
    localparam logic [7:0] TypeSet   = 8'h4;
    localparam logic [7:0] TypePing  = 8'h6;

    localparam int FlagEnd = 0;
    localparam int FlagAck = 0;
    localparam int FlagPad = 3;

    localparam logic ErrProtocol  = 1'b0;
    localparam logic ErrFrameSize = 1'b1;

    typedef struct packed {
        t_ev_code    event_res;
        logic [30:0] stream_id;
        logic [7:0]  data_byte;
        logic [30:0] dependency_id;
        logic        exclusive;
        logic [7:0]  weight;
        logic [31:0] reset_code;
        logic [15:0] setting_id;
        logic [31:0] setting_value;
        logic [63:0] ping_data;
        logic        ack;
        logic        error_kind;
    } t_event;

    typedef struct packed {
        logic   valid;
        t_event evt;
    } t_slot;

endpackage

// ===== src/http2_byte_if.sv =====
// Byte channel into the HTTP/2 frame parser: valid, ready and one connection byte.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
interface http2_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// ===== src/http2_event_if.sv =====
// Event channel out of the HTTP/2 frame parser: valid, ready and the event fields.
// Depends on h2fp_pkg for the event code type.
`timescale 1ns / 1ps
interface http2_event_if;
    logic                valid;
    logic                ready;
    h2fp_pkg::t_ev_code  event_res;
    logic [30:0]         stream_id;
    logic [7:0]          data_byte;
    logic [30:0]         dependency_id;
    logic                exclusive;
    logic [7:0]          weight;
    logic [31:0]         reset_code;
    logic [15:0]         setting_id;
    logic [31:0]         setting_value;
    logic [63:0]         ping_data;
    logic                ack;
    logic                error_kind;

    modport source (output valid, output event_res, output stream_id, output data_byte,
                    output dependency_id, output exclusive, output weight, output reset_code,
                    output setting_id, output setting_value, output ping_data, output ack,
                    output error_kind, input ready);
    modport sink (input valid, input event_res, input stream_id, input data_byte,
                  input dependency_id, input exclusive, input weight, input reset_code,
                  input setting_id, input setting_value, input ping_data, input ack,
                  input error_kind, output ready);
endinterface

// ===== src/http2_frame_parser.sv =====
// HTTP/2 frame parser: takes one connection byte per beat and gives one event per beat. A byte
// is taken every cycle while the event queue between parser and output register has two free
// entries, so the input runs at one byte per cycle as long as events drain; a byte that closes
// a frame can add a second event, and the single output register drains one event per cycle
// while o_out.ready is high. The frame size limit resets to 16384 and is written through
// i_frame_limit_we; the user must write it only while no frame is in flight (not enforced).
// Top level; depends on h2fp_pkg, both channel interfaces, h2fp_front, h2fp_queue, h2fp_back.
`timescale 1ns / 1ps
module http2_frame_parser #(
    parameter int QueueDepth = h2fp_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_frame_limit_we,
    input  logic [23:0]   i_frame_limit,
    http2_byte_if.sink    i_in,
    http2_event_if.source o_out
);

    logic [23:0]      r_frame_limit;
    h2fp_pkg::t_slot  slot_a;
    h2fp_pkg::t_slot  slot_b;
    logic             space;
    logic             q_valid;
    h2fp_pkg::t_event q_evt;
    logic             pop;

    // Hold the frame size limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= h2fp_pkg::MaxFrameSizeReset;
        end else if (i_frame_limit_we) begin
            r_frame_limit <= i_frame_limit;
        end
    end

    h2fp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_space       (space),
        .i_frame_limit (r_frame_limit),
        .o_slot_a      (slot_a),
        .o_slot_b      (slot_b)
    );

    h2fp_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_slot_a (slot_a),
        .i_slot_b (slot_b),
        .i_pop    (pop),
        .o_space  (space),
        .o_valid  (q_valid),
        .o_evt    (q_evt)
    );

    h2fp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_evt   (q_evt),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== src/h2fp_front.sv =====
// Front end of the HTTP/2 frame parser: header and payload byte parsing into up to two events.
// Depends on h2fp_pkg and http2_byte_if.
`timescale 1ns / 1ps
module h2fp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    http2_byte_if.sink          i_in,
    input  logic                i_space,
    input  logic [23:0]         i_frame_limit,
    output h2fp_pkg::t_slot     o_slot_a,
    output h2fp_pkg::t_slot     o_slot_b
);

    logic [3:0]  r_hdr_cnt, n_hdr_cnt;
    logic        r_in_pay, n_in_pay;
    logic [23:0] r_len, n_len;
    logic [7:0]  r_typ, n_typ;
    logic [7:0]  r_flg, n_flg;
    logic [30:0] r_sid, n_sid;
    logic [23:0] r_pcnt, n_pcnt;
    logic [7:0]  r_pad, n_pad;
    logic [2:0]  r_ecnt, n_ecnt;
    logic [63:0] r_vsh, n_vsh;
    logic        accept;
    logic [7:0]  b;
    logic [47:0] set_word;
    logic        last;

    // Error event on a given stream
    function automatic h2fp_pkg::t_slot err_slot(input logic [30:0] sid, input logic kind);
        h2fp_pkg::t_slot s;
        s = '0;
        s.valid = 1'b1;
        s.evt.event_res = h2fp_pkg::EV_ERR;
        s.evt.stream_id = sid;
        s.evt.error_kind = kind;
        return s;
    endfunction

    // Left-align a short field so that missing bytes read as zero
    function automatic logic [63:0] align(input logic [63:0] v, input logic [23:0] len,
                                          input logic [2:0] need);
        logic [2:0] d;
        d = need - len[2:0];
        if (len < 24'(need)) begin
            return v << {d, 3'b000};
        end
        return v;
    endfunction

    // Checks and closing event at the end of a frame
    function automatic h2fp_pkg::t_slot end_slot(input logic [7:0] typ, input logic [7:0] flg,
                                                 input logic [23:0] len, input logic [30:0] sid,
                                                 input logic [7:0] pad, input logic [63:0] vsh);
        h2fp_pkg::t_slot s;
        logic [63:0]     va;
        s = '0;
        s.evt.stream_id = sid;
        va = '0;
        case (typ)
            h2fp_pkg::TypeData: begin
                if (sid == '0) begin
                    s = err_slot(sid, h2fp_pkg::ErrProtocol);
                end else if (flg[h2fp_pkg::FlagPad] && (len == '0 || 24'(pad) >= len)) begin
                    s = err_slot(sid, h2fp_pkg::ErrProtocol);
                end else if (flg[h2fp_pkg::FlagEnd]) begin
                    s.valid = 1'b1;
                    s.evt.event_res = h2fp_pkg::EV_END;
                end
            end
            h2fp_pkg::TypePrio: begin
                if (sid == '0) begin
                    s = err_slot(sid, h2fp_pkg::ErrProtocol);
                end else begin
                    va = align(vsh, len, 3'd5);
                    s.valid = 1'b1;
                    s.evt.event_res = h2fp_pkg::EV_PRIO;
                    s.evt.dependency_id = va[38:8];
                    s.evt.exclusive = va[39];
                    s.evt.weight = va[7:0];
                end
            end
            h2fp_pkg::TypeRst: begin
                if (sid == '0) begin
                    s = err_slot(sid, h2fp_pkg::ErrProtocol);
                end else begin
                    va = align(vsh, len, 3'd4);
                    s.valid = 1'b1;
                    s.evt.event_res = h2fp_pkg::EV_RST;
                    s.evt.reset_code = va[31:0];
                end
            end
            h2fp_pkg::TypeSet: begin
                if (sid != '0) begin
                    s = err_slot(sid, h2fp_pkg::ErrProtocol);
                end else if (len == '0) begin
                    s.valid = 1'b1;
                    s.evt.event_res = h2fp_pkg::EV_SET;
                    s.evt.ack = flg[h2fp_pkg::FlagAck];
                end
            end
            h2fp_pkg::TypePing: begin
                if (len != 24'd8) begin
                    s = err_slot(sid, h2fp_pkg::ErrFrameSize);
                end else if (sid != '0) begin
                    s = err_slot(sid, h2fp_pkg::ErrProtocol);
                end else begin
                    s.valid = 1'b1;
                    s.evt.event_res = h2fp_pkg::EV_PING;
                    s.evt.ping_data = vsh;
                    s.evt.ack = flg[h2fp_pkg::FlagAck];
                end
            end
            default: begin
                s = '0;
            end
        endcase
        return s;
    endfunction

    assign i_in.ready = i_space;
    assign accept = i_in.valid && i_space;
    assign b = i_in.in_byte;
    assign set_word = {r_vsh[39:0], b};
    assign last = ({1'b0, r_pcnt} + 25'd1) >= {1'b0, r_len};

    // Parse one byte: header fields, then payload
    always_comb begin
        n_hdr_cnt = r_hdr_cnt;
        n_in_pay = r_in_pay;
        n_len = r_len;
        n_typ = r_typ;
        n_flg = r_flg;
        n_sid = r_sid;
        n_pcnt = r_pcnt;
        n_pad = r_pad;
        n_ecnt = r_ecnt;
        n_vsh = r_vsh;
        o_slot_a = '0;
        o_slot_b = '0;
        if (accept) begin
            if (!r_in_pay) begin
                if (r_hdr_cnt == 4'd0) begin
                    n_len = '0;
                    n_sid = '0;
                end
                if (r_hdr_cnt < 4'd3) begin
                    n_len = {n_len[15:0], b};
                end else if (r_hdr_cnt == 4'd3) begin
                    n_typ = b;
                end else if (r_hdr_cnt == 4'd4) begin
                    n_flg = b;
                end else begin
                    n_sid = {n_sid[22:0], b};
                end
                n_hdr_cnt = r_hdr_cnt + 4'd1;
                if (r_hdr_cnt == 4'd8) begin
                    n_hdr_cnt = '0;
                    n_pcnt = '0;
                    n_pad = '0;
                    n_ecnt = '0;
                    n_vsh = '0;
                    if (n_len > i_frame_limit) begin
                        n_sid = '0;
                        o_slot_a = err_slot('0, h2fp_pkg::ErrProtocol);
                    end else if (n_len == '0) begin
                        o_slot_a = end_slot(n_typ, n_flg, n_len, n_sid, '0, '0);
                    end else begin
                        n_in_pay = 1'b1;
                    end
                end
            end else begin
                case (r_typ)
                    h2fp_pkg::TypeData: begin
                        if (r_flg[h2fp_pkg::FlagPad]) begin
                            if (r_pcnt == '0) begin
                                n_pad = b;
                            end else if (r_sid != '0 &&
                                         ({1'b0, r_pcnt} + 25'(r_pad)) < {1'b0, r_len}) begin
                                o_slot_a.valid = 1'b1;
                                o_slot_a.evt.event_res = h2fp_pkg::EV_BODY;
                                o_slot_a.evt.stream_id = r_sid;
                                o_slot_a.evt.data_byte = b;
                            end
                        end else if (r_sid != '0) begin
                            o_slot_a.valid = 1'b1;
                            o_slot_a.evt.event_res = h2fp_pkg::EV_BODY;
                            o_slot_a.evt.stream_id = r_sid;
                            o_slot_a.evt.data_byte = b;
                        end
                    end
                    h2fp_pkg::TypePrio: begin
                        if (r_pcnt < 24'd5) begin
                            n_vsh = {r_vsh[55:0], b};
                        end
                    end
                    h2fp_pkg::TypeRst: begin
                        if (r_pcnt < 24'd4) begin
                            n_vsh = {r_vsh[55:0], b};
                        end
                    end
                    h2fp_pkg::TypePing: begin
                        if (r_pcnt < 24'd8) begin
                            n_vsh = {r_vsh[55:0], b};
                        end
                    end
                    h2fp_pkg::TypeSet: begin
                        if (r_ecnt >= 3'd5) begin
                            if (r_sid == '0) begin
                                o_slot_a.valid = 1'b1;
                                o_slot_a.evt.event_res = h2fp_pkg::EV_SET;
                                o_slot_a.evt.setting_id = set_word[47:32];
                                o_slot_a.evt.setting_value = set_word[31:0];
                                o_slot_a.evt.ack = r_flg[h2fp_pkg::FlagAck];
                            end
                            n_ecnt = '0;
                            n_vsh = '0;
                        end else begin
                            n_vsh = {16'd0, set_word};
                            n_ecnt = r_ecnt + 3'd1;
                        end
                    end
                    default: begin
                        n_vsh = r_vsh;
                    end
                endcase
                n_pcnt = r_pcnt + 24'd1;
                if (last) begin
                    o_slot_b = end_slot(r_typ, r_flg, r_len, r_sid, n_pad, n_vsh);
                    n_in_pay = 1'b0;
                    n_hdr_cnt = '0;
                end
            end
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt <= '0;
            r_in_pay <= 1'b0;
            r_len <= '0;
            r_typ <= '0;
            r_flg <= '0;
            r_sid <= '0;
            r_pcnt <= '0;
            r_pad <= '0;
            r_ecnt <= '0;
            r_vsh <= '0;
        end else begin
            r_hdr_cnt <= n_hdr_cnt;
            r_in_pay <= n_in_pay;
            r_len <= n_len;
            r_typ <= n_typ;
            r_flg <= n_flg;
            r_sid <= n_sid;
            r_pcnt <= n_pcnt;
            r_pad <= n_pad;
            r_ecnt <= n_ecnt;
            r_vsh <= n_vsh;
        end
    end

endmodule

// ===== src/h2fp_queue.sv =====
// Event queue of the HTTP/2 frame parser: up to two events in per cycle, one out.
// Depends on h2fp_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "http2_frame_parser_defines.svh"
module h2fp_queue #(
    parameter int Depth = h2fp_pkg::QueueDepth  // power of two, at least 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  h2fp_pkg::t_slot  i_slot_a,
    input  h2fp_pkg::t_slot  i_slot_b,
    input  logic             i_pop,
    output logic             o_space,
    output logic             o_valid,
    output h2fp_pkg::t_event o_evt
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    h2fp_pkg::t_event r_mem [Depth];
    logic [PtrW-1:0]  r_wp, n_wp;
    logic [PtrW-1:0]  r_rp, n_rp;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic [1:0]       pushes;
    logic             pop;

    assign o_space = r_cnt <= CntW'(Depth - 2);
    assign o_valid = r_cnt != '0;
    assign o_evt = r_mem[r_rp];
    assign pop = i_pop && o_valid;
    assign pushes = 2'(i_slot_a.valid) + 2'(i_slot_b.valid);

    // Advance pointers and fill count
    always_comb begin
        n_wp = r_wp + PtrW'(pushes);
        n_rp = r_rp + PtrW'(pop);
        n_cnt = r_cnt + CntW'(pushes) - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store events in order, packing the second one down when the first is absent
    always_ff @(posedge i_clk) begin
        if (i_slot_a.valid) begin
            r_mem[r_wp] <= i_slot_a.evt;
            if (i_slot_b.valid) begin
                r_mem[r_wp + PtrW'(1)] <= i_slot_b.evt;
            end
        end else if (i_slot_b.valid) begin
            r_mem[r_wp] <= i_slot_b.evt;
        end
    end

    `H2FP_CHECK(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CntW'(Depth), "queue count above depth")
    `H2FP_NEVER(a_no_overflow, i_clk, i_rst_n, pushes != 2'd0 && !o_space, "push with no room")
    `H2FP_CHECK(a_ptr_track, i_clk, i_rst_n, PtrW'(r_wp - r_rp) == PtrW'(r_cnt), "pointers disagree with count")

endmodule

// ===== src/h2fp_back.sv =====
// Back end of the HTTP/2 frame parser: output register that presents one event per beat.
// Depends on h2fp_pkg and http2_event_if.
`timescale 1ns / 1ps
module h2fp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  h2fp_pkg::t_event i_evt,
    output logic             o_pop,
    http2_event_if.source    o_out
);

    logic             r_valid, n_valid;
    h2fp_pkg::t_event r_evt;

    // Take the next event when the register is empty or its beat is taken
    assign o_pop = i_valid && (!r_valid || o_out.ready);
    assign n_valid = o_pop || (r_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_evt <= i_evt;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.event_res = r_evt.event_res;
    assign o_out.stream_id = r_evt.stream_id;
    assign o_out.data_byte = r_evt.data_byte;
    assign o_out.dependency_id = r_evt.dependency_id;
    assign o_out.exclusive = r_evt.exclusive;
    assign o_out.weight = r_evt.weight;
    assign o_out.reset_code = r_evt.reset_code;
    assign o_out.setting_id = r_evt.setting_id;
    assign o_out.setting_value = r_evt.setting_value;
    assign o_out.ping_data = r_evt.ping_data;
    assign o_out.ack = r_evt.ack;
    assign o_out.error_kind = r_evt.error_kind;

endmodule
